@@ rtl/cfpa_pkg.sv @@
// Shared types, opcodes, status codes and the CORDIC angle table for the complex ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfpa_pkg;

   localparam int DATA_WIDTH_DEF    = 32;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int PORT_W            = 32;
   localparam int PRESCALE          = 16;
   localparam int QUEUE_DEPTH       = 4;

   typedef logic [2:0] op_type;
   localparam op_type OP_ADD   = 3'd0;
   localparam op_type OP_SUB   = 3'd1;
   localparam op_type OP_MUL   = 3'd2;
   localparam op_type OP_DIV   = 3'd3;
   localparam op_type OP_CONJ  = 3'd4;
   localparam op_type OP_MAG   = 3'd5;
   localparam op_type OP_PHASE = 3'd6;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_UNDEF = 2'd1;
   localparam status_type ST_SAT   = 2'd2;

   typedef struct packed {
      op_type            op;
      logic              op_ok;
      logic [PORT_W-1:0] a_re;
      logic [PORT_W-1:0] a_im;
      logic [PORT_W-1:0] b_re;
      logic [PORT_W-1:0] b_im;
   } item_type;

   // atan(2^-i) in degrees, 16 fractional bits
   function automatic logic [63:0] atan_deg_q16(input int idx);
      logic [63:0] t;
      unique case (idx)
         0:  t = 64'd2949120;
         1:  t = 64'd1740967;
         2:  t = 64'd919879;
         3:  t = 64'd466945;
         4:  t = 64'd234379;
         5:  t = 64'd117304;
         6:  t = 64'd58666;
         7:  t = 64'd29335;
         8:  t = 64'd14668;
         9:  t = 64'd7334;
         10: t = 64'd3667;
         11: t = 64'd1833;
         12: t = 64'd917;
         13: t = 64'd458;
         14: t = 64'd229;
         15: t = 64'd115;
         16: t = 64'd57;
         17: t = 64'd29;
         18: t = 64'd14;
         19: t = 64'd7;
         20: t = 64'd4;
         21: t = 64'd2;
         22: t = 64'd1;
         default: t = 64'd0;
      endcase
      return t;
   endfunction

   // table entry rescaled to the given number of fraction bits, rounded
   function automatic logic [63:0] cordic_angle(input int idx, input int frac);
      logic [63:0] t;
      t = atan_deg_q16(idx);
      if (frac >= 16) begin
         return t << (frac - 16);
      end
      return (t + ((64'd1 << (16 - frac)) >> 1)) >> (16 - frac);
   endfunction

endpackage

`default_nettype wire

@@ rtl/complex_fixed_point_alu_core.sv @@
// Complex fixed-point ALU: add, subtract, multiply, divide, conjugate, magnitude, phase.
// Requests pass through the front-end hold register, the queue, the product and setup stages, the
// iteration stages and the result register; the divider resolves one quotient bit per stage.
// Throughput: one transaction per cycle; the pipeline stalls only when the response is held.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
// Depends on cfpa_pkg, cfpa_front, cfpa_queue, cfpa_back.
`default_nettype none

module complex_fixed_point_alu_core
   import cfpa_pkg::*;
#(
   parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire op_type            req_op,
   input  wire logic [PORT_W-1:0] req_a_re,
   input  wire logic [PORT_W-1:0] req_a_im,
   input  wire logic [PORT_W-1:0] req_b_re,
   input  wire logic [PORT_W-1:0] req_b_im,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PORT_W-1:0]      rsp_res_re,
   output logic [PORT_W-1:0]      rsp_res_im,
   output status_type             rsp_status
);

   logic     push, q_full, pop, q_not_empty;
   item_type push_item, pop_item;

   cfpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_a_re  (req_a_re),
      .req_a_im  (req_a_im),
      .req_b_re  (req_b_re),
      .req_b_im  (req_b_im),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   cfpa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (q_not_empty)
   );

   cfpa_back #(
      .DATA_WIDTH    (DATA_WIDTH),
      .FRAC_BITS     (FRAC_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_not_empty),
      .in_item    (pop_item),
      .in_pop     (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_res_re (rsp_res_re),
      .rsp_res_im (rsp_res_im),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

@@ rtl/cfpa_front.sv @@
// Front end: takes request transactions, checks the opcode and holds one item.
// Depends on cfpa_pkg; feeds cfpa_queue.
`default_nettype none

module cfpa_front
   import cfpa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire op_type            req_op,
   input  wire logic [PORT_W-1:0] req_a_re,
   input  wire logic [PORT_W-1:0] req_a_im,
   input  wire logic [PORT_W-1:0] req_b_re,
   input  wire logic [PORT_W-1:0] req_b_im,
   output logic                   push,
   output item_type               push_item,
   input  wire logic              q_full
);

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff, hold_item_in;
   logic     accept;

   assign req_stall = hold_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = hold_valid_ff & ~q_full;
   assign push_item = hold_item_ff;

   always_comb begin
      hold_item_in       = hold_item_ff;
      hold_valid_in      = hold_valid_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in      = 1'b1;
         hold_item_in.op    = req_op;
         hold_item_in.op_ok = (req_op <= OP_PHASE);
         hold_item_in.a_re  = req_a_re;
         hold_item_in.a_im  = req_a_im;
         hold_item_in.b_re  = req_b_re;
         hold_item_in.b_im  = req_b_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

endmodule

`default_nettype wire

@@ rtl/cfpa_queue.sv @@
// Small register FIFO between the front end and the arithmetic back end.
// Depends on cfpa_pkg for the item type.
`default_nettype none

module cfpa_queue
   import cfpa_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_item,
   output logic          not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   item_type         entry_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push & ~pop) begin
         count_in = count_ff + CNW'(1);
      end else if (pop & ~push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNW'(DEPTH)) || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(DEPTH))
      else $error("queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNW'(1))
      else $error("queue count did not follow push");

endmodule

`default_nettype wire

@@ rtl/cfpa_back.sv @@
// Back end: pipelined complex arithmetic (products, long division, square root,
// vectoring CORDIC) with a registered result stage. Depends on cfpa_pkg.
`default_nettype none

module cfpa_back
   import cfpa_pkg::*;
#(
   parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire item_type    in_item,
   output logic             in_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [PORT_W-1:0] rsp_res_re,
   output logic [PORT_W-1:0] rsp_res_im,
   output status_type       rsp_status
);

   localparam int WW   = (DATA_WIDTH < PORT_W) ? DATA_WIDTH : PORT_W;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * WW;
   localparam int MAGW = PW + 1;
   localparam int NW   = PW + F + 1;
   localparam int CW   = ((NW > 3 * WW) ? NW : 3 * WW) + 1;
   localparam int XW   = WW + PRESCALE + 3;
   localparam int ZW   = F + 10;
   localparam int LW   = PW + 2;
   localparam int CS   = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
   localparam int QS   = WW + 1;
   localparam int NI   = (QS > CS) ? QS : CS;

   localparam logic signed [LW-1:0] WMAX_L = (LW'(1) << (WW - 1)) - LW'(1);
   localparam logic signed [LW-1:0] WMIN_L = -WMAX_L - LW'(1);
   localparam logic [MAGW-1:0]      WMAX_U = (MAGW'(1) << (WW - 1)) - MAGW'(1);
   localparam logic signed [ZW-1:0] HALF   = ZW'(180) << F;

   typedef struct packed {
      logic signed [WW-1:0] v;
      logic                 s;
   } sat_type;

   typedef struct packed {
      op_type               op;
      logic                 ok;
      logic signed [WW-1:0] a;
      logic signed [WW-1:0] b;
      logic signed [WW-1:0] c;
      logic signed [WW-1:0] d;
      logic signed [PW-1:0] ac;
      logic signed [PW-1:0] bd;
      logic signed [PW-1:0] ad;
      logic signed [PW-1:0] bc;
      logic signed [PW-1:0] aa;
      logic signed [PW-1:0] bb;
      logic signed [PW-1:0] cc;
      logic signed [PW-1:0] dd;
   } prod_type;

   typedef struct packed {
      op_type               op;
      logic                 ok;
      logic signed [WW-1:0] fast_re;
      logic signed [WW-1:0] fast_im;
      logic                 fast_sat;
      logic                 den_zero;
      logic [PW-1:0]        den;
      logic                 neg_re;
      logic                 neg_im;
      logic [CW-1:0]        rem_re;
      logic [CW-1:0]        rem_im;
      logic                 big_re;
      logic                 big_im;
      logic [WW-1:0]        q_re;
      logic [WW-1:0]        q_im;
      logic [PW-1:0]        sq_n;
      logic [PW-1:0]        sq_res;
      logic                 ph_zero;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } iter_type;

   function automatic sat_type sat_val(input logic signed [LW-1:0] v);
      sat_type r;
      r.s = 1'b0;
      r.v = v[WW-1:0];
      if (v > WMAX_L) begin
         r.s = 1'b1;
         r.v = WMAX_L[WW-1:0];
      end else if (v < WMIN_L) begin
         r.s = 1'b1;
         r.v = WMIN_L[WW-1:0];
      end
      return r;
   endfunction

   function automatic sat_type sat_mag(input logic neg, input logic [MAGW-1:0] m);
      sat_type r;
      r.s = 1'b0;
      if (!neg) begin
         r.v = m[WW-1:0];
         if (m > WMAX_U) begin
            r.s = 1'b1;
            r.v = WMAX_L[WW-1:0];
         end
      end else begin
         r.v = WW'(MAGW'(0) - m);
         if (m > WMAX_U + MAGW'(1)) begin
            r.s = 1'b1;
            r.v = WMIN_L[WW-1:0];
         end
      end
      return r;
   endfunction

   logic           advance;
   logic           rsp_valid_ff;
   logic           p1_valid_ff;
   prod_type       p1_ff, p1_in;
   logic [NI:0]    it_valid_ff;
   iter_type       it_ff [0:NI];
   iter_type       it_in [1:NI];
   iter_type       s2_in;

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign in_pop  = advance & in_valid;

   // ---------------- stage 1: operand products ----------------
   always_comb begin
      p1_in.op = in_item.op;
      p1_in.ok = in_item.op_ok;
      p1_in.a  = signed'(in_item.a_re[WW-1:0]);
      p1_in.b  = signed'(in_item.a_im[WW-1:0]);
      p1_in.c  = signed'(in_item.b_re[WW-1:0]);
      p1_in.d  = signed'(in_item.b_im[WW-1:0]);
      p1_in.ac = PW'(p1_in.a) * PW'(p1_in.c);
      p1_in.bd = PW'(p1_in.b) * PW'(p1_in.d);
      p1_in.ad = PW'(p1_in.a) * PW'(p1_in.d);
      p1_in.bc = PW'(p1_in.b) * PW'(p1_in.c);
      p1_in.aa = PW'(p1_in.a) * PW'(p1_in.a);
      p1_in.bb = PW'(p1_in.b) * PW'(p1_in.b);
      p1_in.cc = PW'(p1_in.c) * PW'(p1_in.c);
      p1_in.dd = PW'(p1_in.d) * PW'(p1_in.d);
   end

   // ---------------- stage 2: sums, rounding, iteration setup ----------------
   logic signed [WW:0]  s_add_re, s_add_im, s_sub_re, s_sub_im;
   logic signed [PW:0]  m_re_s, m_im_s, d_re_s, d_im_s;
   logic [PW-1:0]       m_re_m, m_im_m, d_re_m, d_im_m;
   logic [MAGW-1:0]     m_re_r, m_im_r;
   logic signed [XW-1:0] x0, y0;
   sat_type             fre, fim, mul_re, mul_im;

   always_comb begin
      s_add_re = (WW+1)'(p1_ff.a) + (WW+1)'(p1_ff.c);
      s_add_im = (WW+1)'(p1_ff.b) + (WW+1)'(p1_ff.d);
      s_sub_re = (WW+1)'(p1_ff.a) - (WW+1)'(p1_ff.c);
      s_sub_im = (WW+1)'(p1_ff.b) - (WW+1)'(p1_ff.d);

      m_re_s = (PW+1)'(p1_ff.ac) - (PW+1)'(p1_ff.bd);
      m_im_s = (PW+1)'(p1_ff.ad) + (PW+1)'(p1_ff.bc);
      m_re_m = m_re_s[PW] ? PW'(-m_re_s) : m_re_s[PW-1:0];
      m_im_m = m_im_s[PW] ? PW'(-m_im_s) : m_im_s[PW-1:0];
      m_re_r = (MAGW'(m_re_m) + (MAGW'(1) << (F - 1))) >> F;
      m_im_r = (MAGW'(m_im_m) + (MAGW'(1) << (F - 1))) >> F;
      mul_re = sat_mag(m_re_s[PW], m_re_r);
      mul_im = sat_mag(m_im_s[PW], m_im_r);

      d_re_s = (PW+1)'(p1_ff.ac) + (PW+1)'(p1_ff.bd);
      d_im_s = (PW+1)'(p1_ff.bc) - (PW+1)'(p1_ff.ad);
      d_re_m = d_re_s[PW] ? PW'(-d_re_s) : d_re_s[PW-1:0];
      d_im_m = d_im_s[PW] ? PW'(-d_im_s) : d_im_s[PW-1:0];

      unique case (p1_ff.op)
         OP_ADD: begin
            fre = sat_val(LW'(s_add_re));
            fim = sat_val(LW'(s_add_im));
         end
         OP_SUB: begin
            fre = sat_val(LW'(s_sub_re));
            fim = sat_val(LW'(s_sub_im));
         end
         OP_CONJ: begin
            fre.v = p1_ff.a;
            fre.s = 1'b0;
            fim   = sat_val(-(LW'(p1_ff.b)));
         end
         OP_MUL: begin
            fre = mul_re;
            fim = mul_im;
         end
         default: begin
            fre = '0;
            fim = '0;
         end
      endcase

      s2_in.op       = p1_ff.op;
      s2_in.ok       = p1_ff.ok;
      s2_in.fast_re  = fre.v;
      s2_in.fast_im  = fim.v;
      s2_in.fast_sat = fre.s | fim.s;

      s2_in.den      = PW'(p1_ff.cc) + PW'(p1_ff.dd);
      s2_in.den_zero = (s2_in.den == '0);
      s2_in.neg_re   = d_re_s[PW];
      s2_in.neg_im   = d_im_s[PW];
      // dividend carries the half-divisor so the quotient comes out rounded
      s2_in.rem_re   = (CW'(d_re_m) << F) + CW'(s2_in.den >> 1);
      s2_in.rem_im   = (CW'(d_im_m) << F) + CW'(s2_in.den >> 1);
      s2_in.big_re   = 1'b0;
      s2_in.big_im   = 1'b0;
      s2_in.q_re     = '0;
      s2_in.q_im     = '0;

      s2_in.sq_n     = PW'(p1_ff.aa) + PW'(p1_ff.bb);
      s2_in.sq_res   = '0;

      s2_in.ph_zero  = (p1_ff.a == '0) && (p1_ff.b == '0);
      x0 = XW'(p1_ff.a) <<< PRESCALE;
      y0 = XW'(p1_ff.b) <<< PRESCALE;
      // left half plane: rotate by 180 degrees first
      if (p1_ff.a < 0) begin
         s2_in.x = -x0;
         s2_in.y = -y0;
         s2_in.z = (p1_ff.b >= 0) ? HALF : -HALF;
      end else begin
         s2_in.x = x0;
         s2_in.y = y0;
         s2_in.z = '0;
      end
   end

   // ---------------- iteration stages ----------------
   for (genvar k = 0; k < NI; k++) begin : g_iter
      iter_type      nxt;
      logic [CW-1:0] sh_den;
      logic [PW:0]   trial;

      assign sh_den = (k == 0) ? (CW'(it_ff[k].den) << WW)
                               : (CW'(it_ff[k].den) << ((k == 0) ? 0 : WW - k));

      always_comb begin
         nxt   = it_ff[k];
         trial = '0;
         if (k == 0) begin
            nxt.big_re = (it_ff[k].rem_re >= sh_den);
            nxt.big_im = (it_ff[k].rem_im >= sh_den);
         end else if (k < QS) begin
            if (it_ff[k].rem_re >= sh_den) begin
               nxt.rem_re        = it_ff[k].rem_re - sh_den;
               nxt.q_re[WW - k]  = 1'b1;
            end
            if (it_ff[k].rem_im >= sh_den) begin
               nxt.rem_im        = it_ff[k].rem_im - sh_den;
               nxt.q_im[WW - k]  = 1'b1;
            end
         end
         if (k < WW) begin
            trial = (PW+1)'(it_ff[k].sq_res)
                  + ((PW+1)'(1) << ((k < WW) ? 2 * (WW - 1 - k) : 0));
            if ((PW+1)'(it_ff[k].sq_n) >= trial) begin
               nxt.sq_n   = it_ff[k].sq_n - trial[PW-1:0];
               nxt.sq_res = (it_ff[k].sq_res >> 1)
                          + (PW'(1) << ((k < WW) ? 2 * (WW - 1 - k) : 0));
            end else begin
               nxt.sq_res = it_ff[k].sq_res >> 1;
            end
         end
         if (k < CS) begin
            if (it_ff[k].y > 0) begin
               nxt.x = it_ff[k].x + (it_ff[k].y >>> k);
               nxt.y = it_ff[k].y - (it_ff[k].x >>> k);
               nxt.z = it_ff[k].z + ZW'(signed'(cordic_angle(k, F)));
            end else begin
               nxt.x = it_ff[k].x - (it_ff[k].y >>> k);
               nxt.y = it_ff[k].y + (it_ff[k].x >>> k);
               nxt.z = it_ff[k].z - ZW'(signed'(cordic_angle(k, F)));
            end
         end
      end

      assign it_in[k + 1] = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         it_valid_ff <= '0;
      end else if (advance) begin
         p1_valid_ff <= in_pop;
         it_valid_ff <= {it_valid_ff[NI-1:0], p1_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff    <= p1_in;
         it_ff[0] <= s2_in;
         for (int i = 1; i <= NI; i++) begin
            it_ff[i] <= it_in[i];
         end
      end
   end

   // ---------------- result selection and output register ----------------
   iter_type             last;
   logic [MAGW-1:0]      root;
   logic signed [ZW-1:0] zc;
   sat_type              r_re, r_im;
   logic signed [WW-1:0] fin_re, fin_im;
   status_type           fin_st;
   logic [PORT_W-1:0]    rsp_re_ff, rsp_im_ff;
   status_type           rsp_st_ff;

   always_comb begin
      last = it_ff[NI];
      root = (MAGW'(last.sq_n) > MAGW'(last.sq_res)) ? MAGW'(last.sq_res) + MAGW'(1)
                                                     : MAGW'(last.sq_res);
      zc   = (last.z > HALF) ? HALF : ((last.z < -HALF) ? -HALF : last.z);
      r_re = '0;
      r_im = '0;
      fin_re = '0;
      fin_im = '0;
      fin_st = ST_UNDEF;
      if (last.ok) begin
         unique case (last.op)
            OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
               fin_re = last.fast_re;
               fin_im = last.fast_im;
               fin_st = last.fast_sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
               if (!last.den_zero) begin
                  r_re = sat_mag(last.neg_re, last.big_re ? '1 : MAGW'(last.q_re));
                  r_im = sat_mag(last.neg_im, last.big_im ? '1 : MAGW'(last.q_im));
                  fin_re = r_re.v;
                  fin_im = r_im.v;
                  fin_st = (r_re.s | r_im.s) ? ST_SAT : ST_OK;
               end
            end
            OP_MAG: begin
               r_re   = sat_mag(1'b0, root);
               fin_re = r_re.v;
               fin_st = r_re.s ? ST_SAT : ST_OK;
            end
            OP_PHASE: begin
               if (!last.ph_zero) begin
                  r_re   = sat_val(LW'(zc));
                  fin_re = r_re.v;
                  fin_st = r_re.s ? ST_SAT : ST_OK;
               end
            end
            default: begin
               fin_st = ST_UNDEF;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= it_valid_ff[NI];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_re_ff <= PORT_W'(fin_re);
         rsp_im_ff <= PORT_W'(fin_im);
         rsp_st_ff <= fin_st;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = rsp_re_ff;
   assign rsp_res_im = rsp_im_ff;
   assign rsp_status = rsp_st_ff;

endmodule

`default_nettype wire

@@ tb/sv/cfpa_checker.sv @@
// Checker for the complex ALU: predicts each accepted request and compares responses in order.
// Depends on cfpa_pkg for opcode and status codes; instantiated beside the DUT in tb_top.
module cfpa_checker
   import cfpa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire op_type            req_op,
   input  wire logic [PORT_W-1:0] req_a_re,
   input  wire logic [PORT_W-1:0] req_a_im,
   input  wire logic [PORT_W-1:0] req_b_re,
   input  wire logic [PORT_W-1:0] req_b_im,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [PORT_W-1:0] rsp_res_re,
   input  wire logic [PORT_W-1:0] rsp_res_im,
   input  wire status_type        rsp_status,
   output int                     fail_count,
   output int                     pending
);

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      status_type  st;
   } alu_result_type;

   // atan(2^-i) in degrees, Q16
   localparam int ATAN_DEG [0:15] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                      58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                      229, 115};

   alu_result_type expected_q[$];

   function automatic logic signed [127:0] sx(input logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   function automatic logic [31:0] clamp_word(input logic signed [127:0] v,
                                              inout status_type st);
      if (v > 128'sd2147483647) begin
         st = ST_SAT;
         return 32'h7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
         st = ST_SAT;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // exact product sum, rounded half away from zero to Q16
   function automatic logic [31:0] mul_round(input logic signed [127:0] s,
                                             inout status_type st);
      logic signed [127:0] m;
      m = (s < 0) ? -s : s;
      m = (m + 128'sd32768) >>> 16;
      return clamp_word((s < 0) ? -m : m, st);
   endfunction

   function automatic logic [31:0] div_round(input logic signed [127:0] s,
                                             input logic signed [127:0] den,
                                             inout status_type st);
      logic signed [127:0] m;
      m = (s < 0) ? -s : s;
      m = ((m <<< 16) + (den >>> 1)) / den;
      return clamp_word((s < 0) ? -m : m, st);
   endfunction

   function automatic logic [63:0] sqrt_round(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return (n > res) ? res + 1 : res;
   endfunction

   function automatic logic signed [63:0] cordic_phase(input logic signed [63:0] xi,
                                                       input logic signed [63:0] yi);
      logic signed [63:0] x, y, z, dx, dy, half;
      half = 64'sd180 <<< 16;
      x = xi <<< 16;
      y = yi <<< 16;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? half : -half;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + ATAN_DEG[i];
         end else begin
            x = x - dx; y = y + dy; z = z - ATAN_DEG[i];
         end
      end
      if (z > half) z = half;
      if (z < -half) z = -half;
      return z;
   endfunction

   function automatic alu_result_type alu_predict(input op_type op, input logic [31:0] ar,
                                                  input logic [31:0] ai,
                                                  input logic [31:0] br,
                                                  input logic [31:0] bi);
      logic signed [127:0] a, b, c, d, den;
      alu_result_type r;
      a = sx(ar); b = sx(ai); c = sx(br); d = sx(bi);
      r.re = 0; r.im = 0; r.st = ST_OK;
      case (op)
         OP_ADD: begin
            r.re = clamp_word(a + c, r.st);
            r.im = clamp_word(b + d, r.st);
         end
         OP_SUB: begin
            r.re = clamp_word(a - c, r.st);
            r.im = clamp_word(b - d, r.st);
         end
         OP_MUL: begin
            r.re = mul_round(a * c - b * d, r.st);
            r.im = mul_round(a * d + b * c, r.st);
         end
         OP_DIV: begin
            den = c * c + d * d;
            if (den == 0) begin
               r.st = ST_UNDEF;
            end else begin
               r.re = div_round(a * c + b * d, den, r.st);
               r.im = div_round(b * c - a * d, den, r.st);
            end
         end
         OP_CONJ: begin
            r.re = ar;
            r.im = clamp_word(-b, r.st);
         end
         OP_MAG: begin
            r.re = clamp_word({64'd0, sqrt_round(64'(a * a + b * b))}, r.st);
         end
         OP_PHASE: begin
            if (a == 0 && b == 0) r.st = ST_UNDEF;
            else r.re = clamp_word(sx(32'(cordic_phase(64'(a), 64'(b)))), r.st);
         end
         default: r.st = ST_UNDEF;
      endcase
      return r;
   endfunction

   assign pending = expected_q.size();

   // all channel signals are stable at the falling edge; a transaction there
   // completes at the following rising edge
   always @(negedge clock) begin
      alu_result_type exp_r;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_q.push_back(alu_predict(req_op, req_a_re, req_a_im, req_b_re, req_b_im));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response re=%h im=%h st=%0d",
                                              rsp_res_re, rsp_res_im, rsp_status);
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r.re !== rsp_res_re || exp_r.im !== rsp_res_im ||
                   exp_r.st !== rsp_status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                              exp_r.re, exp_r.im, exp_r.st,
                              rsp_res_re, rsp_res_im, rsp_status);
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for complex_fixed_point_alu_core: clock, reset, stimulus and verdict.
// Depends on cfpa_pkg, the DUT and cfpa_checker.
module tb_top;
   import cfpa_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   op_type            req_op = OP_ADD;
   logic [PORT_W-1:0] req_a_re = 0, req_a_im = 0, req_b_re = 0, req_b_im = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [PORT_W-1:0] rsp_res_re, rsp_res_im;
   status_type        rsp_status;
   int                fail_count, pending;
   int                send_idle_pct = 0, recv_idle_pct = 0;
   int                cycle_count = 0;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff, MINV = 32'h8000_0000;
   localparam logic [31:0] ONE = 32'h0001_0000, NEG1 = 32'hffff_0000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   complex_fixed_point_alu_core u_top (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_a_re, .req_a_im,
      .req_b_re, .req_b_im, .rsp_valid, .rsp_stall, .rsp_res_re, .rsp_res_im, .rsp_status
   );

   cfpa_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_a_re, .req_a_im,
      .req_b_re, .req_b_im, .rsp_valid, .rsp_stall, .rsp_res_re, .rsp_res_im, .rsp_status,
      .fail_count, .pending
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // called right after a rising edge; leaves at the edge that accepts the transaction
   task automatic send_op(input op_type op, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? MAXV : MINV;
         1: return 32'($signed($urandom_range(8)) - 4) <<< 16;
         2: return 32'($signed($urandom_range(2000)) - 1000);
         3: return 32'($signed($urandom_range(200000)) - 100000) <<< 4;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: each op, extremes, zero divisor, phase of zero, negative real axis
      send_op(OP_ADD, MAXV, MINV, MAXV, MINV);
      send_op(OP_ADD, ONE, NEG1, ONE, ONE);
      send_op(OP_SUB, MINV, MAXV, MAXV, MINV);
      send_op(OP_SUB, ONE, ONE, NEG1, 0);
      send_op(OP_MUL, MAXV, MAXV, MAXV, MINV);
      send_op(OP_MUL, MINV, MINV, MINV, MINV);
      send_op(OP_MUL, 32'h0001_8000, 32'h0000_8000, 32'h0000_0001, 32'hffff_ffff);
      send_op(OP_DIV, ONE, ONE, 0, 0);
      send_op(OP_DIV, MAXV, MINV, 1, 0);
      send_op(OP_DIV, ONE, 0, 32'h0003_0000, 0);
      send_op(OP_DIV, MINV, MINV, MINV, MINV);
      send_op(OP_CONJ, MAXV, MINV, 0, 0);
      send_op(OP_CONJ, NEG1, MAXV, 0, 0);
      send_op(OP_MAG, MINV, MINV, 0, 0);
      send_op(OP_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0);
      send_op(OP_MAG, 1, 1, 0, 0);
      send_op(OP_PHASE, 0, 0, ONE, ONE);
      send_op(OP_PHASE, NEG1, 0, 0, 0);
      send_op(OP_PHASE, MINV, 32'hffff_ffff, 0, 0);
      send_op(OP_PHASE, MINV, 1, 0, 0);
      send_op(OP_PHASE, 0, MINV, 0, 0);
      send_op(OP_PHASE, ONE, ONE, 0, 0);
      send_op(OP_PHASE, MAXV, 0, 0, 0);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 52 : 0;
         recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 9 : 0;
         for (int n = 0; n < 630; n++) begin
            op_type op;
            op = op_type'($urandom_range(6));
            if (op == OP_DIV && $urandom_range(15) == 0)
               send_op(op, rand_operand(), rand_operand(), 0, 0);
            else
               send_op(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
         end
      end
      req_valid <= 0;
      recv_idle_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cfpa_pkg.sv
rtl/cfpa_front.sv
rtl/cfpa_queue.sv
rtl/cfpa_back.sv
rtl/complex_fixed_point_alu_core.sv
tb/sv/cfpa_checker.sv
tb/sv/tb_top.sv
